// ===== rtl/bsc_pkg.sv =====
// ============================================================================
// Barometric sensor compensation package
// Word types, register codes and fixed constants shared by the datapath files.
// ============================================================================
package bsc_pkg;

    // Input word: one raw converter reading pair
    typedef struct packed {
        logic [19:0] adc_temp;
        logic [19:0] adc_pres;
    } in_word_t;

    // Output word: compensated temperature and pressure
    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [24:0]        pressure_q24_8;
        logic               div_error;
    } out_word_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CAL_TEMP   = 2'd0,
        CFG_CAL_PRES_A = 2'd1,
        CFG_CAL_PRES_B = 2'd2,
        CFG_CAL_PRES_C = 2'd3
    } cfg_reg_t;

    // Divider widths: 64-bit dividend, divisor magnitude up to 2^30
    localparam int NUM_W      = 64;
    localparam int DEN_W      = 31;
    localparam int DIV_STAGES = NUM_W;

    // Data that rides alongside the divider
    typedef struct packed {
        logic signed [14:0] temp_centi;
        logic               err;
        logic               neg;
    } div_side_t;

    localparam logic signed [14:0] TEMP_MIN_CENTI = -15'sd4000;
    localparam logic signed [14:0] TEMP_MAX_CENTI = 15'sd8500;
    localparam logic [24:0]        PRES_MAX_Q8    = 25'd28160000;
    localparam logic signed [25:0] TFINE_OFFSET   = 26'sd128000;
    localparam logic [63:0]        PRES_BIAS      = 64'h0000_8000_0000_0000;
    localparam logic [63:0]        NUM_SCALE      = 64'd3125;
    localparam logic [20:0]        ADC_FULL       = 21'd1048576;

endpackage

// ===== rtl/bsc_div.sv =====
// ============================================================================
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, one word per cycle while en is high.
// ============================================================================
module bsc_div
    import bsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vld_in,
    input  logic [NUM_W-1:0] num_in,
    input  logic [DEN_W-1:0] den_in,
    input  div_side_t        side_in,
    output logic             vld_out,
    output logic [NUM_W-1:0] quot_out,
    output div_side_t        side_out
);

    logic             vld_reg  [DIV_STAGES];
    logic [DEN_W-1:0] rem_reg  [DIV_STAGES];
    logic [NUM_W-1:0] quo_reg  [DIV_STAGES];
    logic [DEN_W-1:0] dv_reg   [DIV_STAGES];
    div_side_t        side_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic             v_prev;
        logic [DEN_W-1:0] rem_prev;
        logic [NUM_W-1:0] quo_prev;
        logic [DEN_W-1:0] dv_prev;
        div_side_t        side_prev;
        logic [DEN_W:0]   shifted;
        logic [DEN_W+1:0] trial;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] quo_next;

        if (k == 0) begin : g_first
            assign v_prev    = vld_in;
            assign rem_prev  = '0;
            assign quo_prev  = num_in;
            assign dv_prev   = den_in;
            assign side_prev = side_in;
        end else begin : g_rest
            assign v_prev    = vld_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign dv_prev   = dv_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // shift in the next dividend bit, try to subtract
        assign shifted  = {rem_prev, quo_prev[NUM_W-1]};
        assign trial    = {1'b0, shifted} - {2'b00, dv_prev};
        assign rem_next = trial[DEN_W+1] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
        assign quo_next = {quo_prev[NUM_W-2:0], ~trial[DEN_W+1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                dv_reg[k]   <= dv_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign vld_out  = vld_reg[DIV_STAGES-1];
    assign quot_out = quo_reg[DIV_STAGES-1];
    assign side_out = side_reg[DIV_STAGES-1];

endmodule

// ===== rtl/barometric_sensor_compensation_top.sv =====
// ============================================================================
// Barometric sensor compensation top level
// Integer temperature and pressure compensation pipeline with saturation.
// ============================================================================
// Accepts one raw temperature/pressure word per cycle while sample_stall is
// low and returns one compensated word per accepted word, in order. The
// pipeline is the 64-stage pipelined divider (one quotient bit per stage)
// between eleven front stages of multiply/add, five back stages and the
// output register. When a result waits under stall the pipeline moves one
// more step into a one-word skid register and then holds; the input stalls
// only while that register is full. Calibration registers must be written
// only while no word is in flight. Temperature is in 0.01 degC clamped to
// [-4000, 8500]; pressure is Pa * 256 clamped to [0, 28160000]; a zero
// divisor forces pressure to 0 and sets div_error.
module barometric_sensor_compensation_top
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [63:0] wr_data,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  in_word_t    sample,
    output logic        result_valid,
    input  logic        result_stall,
    output out_word_t   result
);

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    logic [47:0] cal_temp_reg;
    logic [63:0] cal_pres_a_reg;
    logic [63:0] cal_pres_b_reg;
    logic [15:0] cal_pres_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg   <= '0;
            cal_pres_a_reg <= '0;
            cal_pres_b_reg <= '0;
            cal_pres_c_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                CFG_CAL_TEMP:   cal_temp_reg   <= wr_data[47:0];
                CFG_CAL_PRES_A: cal_pres_a_reg <= wr_data;
                CFG_CAL_PRES_B: cal_pres_b_reg <= wr_data;
                CFG_CAL_PRES_C: cal_pres_c_reg <= wr_data[15:0];
                default:        cal_temp_reg   <= cal_temp_reg;
            endcase
        end
    end

    // calibration fields
    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = cal_temp_reg[15:0];
    assign t2 = $signed(cal_temp_reg[31:16]);
    assign t3 = $signed(cal_temp_reg[47:32]);
    assign p1 = cal_pres_a_reg[15:0];
    assign p2 = $signed(cal_pres_a_reg[31:16]);
    assign p3 = $signed(cal_pres_a_reg[47:32]);
    assign p4 = $signed(cal_pres_a_reg[63:48]);
    assign p5 = $signed(cal_pres_b_reg[15:0]);
    assign p6 = $signed(cal_pres_b_reg[31:16]);
    assign p7 = $signed(cal_pres_b_reg[47:32]);
    assign p8 = $signed(cal_pres_b_reg[63:48]);
    assign p9 = $signed(cal_pres_c_reg);

    // ------------------------------------------------------------------
    // Flow control: the pipeline moves unless the skid register is full
    // ------------------------------------------------------------------
    logic      adv;
    logic      out_free;
    logic      result_valid_reg;
    out_word_t result_reg;
    logic      skid_valid_reg;
    out_word_t skid_reg;

    assign adv          = !skid_valid_reg;
    assign sample_stall = skid_valid_reg;
    assign out_free     = !result_valid_reg || !result_stall;

    // valid bits of the front (1..11) and back (12..16) stages
    logic [16:1] v_reg;
    logic        dq_vld;

    // ------------------------------------------------------------------
    // Stage payload registers and next values
    // ------------------------------------------------------------------
    logic [19:0]        at1_reg, ap1_reg, ap2_reg, ap3_reg, ap4_reg, ap5_reg;
    logic [19:0]        ap6_reg, ap7_reg, ap8_reg;
    logic signed [33:0] m1_reg, sq_reg, m1_next, sq_next;
    logic signed [22:0] ta_reg, ta_next;
    logic signed [37:0] m2_reg, m2_next;
    logic signed [24:0] tfine_reg, tfine_next;
    logic signed [14:0] tc5_reg, tc6_reg, tc7_reg, tc8_reg, tc9_reg, tc10_reg, tc_next;
    logic signed [25:0] av_reg, av_next;
    logic signed [51:0] aa_reg, aa_next;
    logic signed [41:0] ap2p_reg, ap5p_reg, ap2p_next, ap5p_next;
    logic signed [41:0] ap2p7_reg, ap5p7_reg;
    logic [63:0]        b6_reg, a3_reg, b6_next, a3_next;
    logic [63:0]        b_reg, x_reg, b_next, x_next;
    logic [47:0]        pl_reg, pl_next;
    logic [31:0]        ph_reg, ph_next;
    logic [63:0]        n0_reg, n0_next;
    logic signed [30:0] den_reg, den_next;
    logic [63:0]        num_reg, num_next;
    logic [63:0]        nmag_reg, nmag_next;
    logic [30:0]        dmag_reg, dmag_next;
    div_side_t          side11_reg, side11_next;

    logic [63:0]        dq_quot;
    div_side_t          dq_side;

    logic [63:0]        q12_reg, q13_reg, q14_reg, q15_reg, q12_next;
    logic signed [14:0] tc12_reg, tc13_reg, tc14_reg, tc15_reg, tc16_reg;
    logic               er12_reg, er13_reg, er14_reg, er15_reg, er16_reg;
    logic [63:0]        t9_reg, a13_reg, t9_next, a13_next;
    logic signed [48:0] pl8_reg, pl8_next;
    logic [31:0]        ph8_reg, ph8_next;
    logic [63:0]        ll_reg, ll_next;
    logic [31:0]        lh_reg, hl_reg, lh_next, hl_next;
    logic [63:0]        b8_reg, b8_next;
    logic [63:0]        c_reg, bb_reg, c_next, bb_next;
    logic [63:0]        s_reg, s_next;
    out_word_t          result_next;

    // Stage 2: temperature differences and first products
    logic signed [17:0] d1;
    logic signed [16:0] d2;
    always_comb
    begin
        d1      = $signed({1'b0, at1_reg[19:3]}) - $signed({1'b0, t1, 1'b0});
        d2      = $signed({1'b0, at1_reg[19:4]}) - $signed({1'b0, t1});
        m1_next = d1 * t2;
        sq_next = d2 * d2;
    end

    // Stage 3: scale, times t3
    logic signed [21:0] sqs;
    always_comb
    begin
        ta_next = $signed(m1_reg[33:11]);
        sqs     = $signed(sq_reg[33:12]);
        m2_next = sqs * t3;
    end

    // Stage 4: fine temperature
    always_comb
    begin
        tfine_next = $signed({{2{ta_reg[22]}}, ta_reg}) + $signed({m2_reg[37], m2_reg[37:14]});
    end

    // Stage 5: centidegrees with clamp, pressure offset term
    logic signed [28:0] t5;
    logic signed [20:0] tsh;
    always_comb
    begin
        t5 = $signed({{4{tfine_reg[24]}}, tfine_reg})
           + $signed({{2{tfine_reg[24]}}, tfine_reg, 2'b00}) + 29'sd128;
        tsh = $signed(t5[28:8]);
        priority if (tsh < 21'(TEMP_MIN_CENTI))
            tc_next = TEMP_MIN_CENTI;
        else if (tsh > 21'(TEMP_MAX_CENTI))
            tc_next = TEMP_MAX_CENTI;
        else
            tc_next = tsh[14:0];
        av_next = $signed({tfine_reg[24], tfine_reg}) - TFINE_OFFSET;
    end

    // Stage 6: square and linear products
    always_comb
    begin
        aa_next   = av_reg * av_reg;
        ap2p_next = av_reg * p2;
        ap5p_next = av_reg * p5;
    end

    // Stage 7: quadratic products, wrapped to 64 bits
    logic signed [67:0] b6_prod, a3_prod;
    always_comb
    begin
        b6_prod = aa_reg * p6;
        a3_prod = aa_reg * p3;
        b6_next = b6_prod[63:0];
        a3_next = a3_prod[63:0];
    end

    // Stage 8: sum the divisor and numerator offset terms
    always_comb
    begin
        b_next = b6_reg + {{5{ap5p7_reg[41]}}, ap5p7_reg, 17'b0}
               + {{13{p4[15]}}, p4, 35'b0};
        x_next = PRES_BIAS + {{8{a3_reg[63]}}, a3_reg[63:8]}
               + {{10{ap2p7_reg[41]}}, ap2p7_reg, 12'b0};
    end

    // Stage 9: divisor times p1 in two halves, raw numerator
    logic [47:0] ph_prod;
    logic [20:0] adc_inv;
    always_comb
    begin
        pl_next = x_reg[31:0] * p1;
        ph_prod = x_reg[63:32] * p1;
        ph_next = ph_prod[31:0];
        adc_inv = ADC_FULL - {1'b0, ap8_reg};
        n0_next = {12'b0, adc_inv, 31'b0} - b_reg;
    end

    // Stage 10: final divisor and scaled numerator
    logic [63:0] dprod;
    always_comb
    begin
        dprod    = {16'b0, pl_reg} + {ph_reg, 32'b0};
        den_next = $signed(dprod[63:33]);
        num_next = n0_reg * NUM_SCALE;
    end

    // Stage 11: magnitudes and signs for the divider
    always_comb
    begin
        nmag_next              = num_reg[63] ? (64'd0 - num_reg) : num_reg;
        dmag_next              = den_reg[30] ? (31'd0 - den_reg) : den_reg;
        side11_next.temp_centi = tc10_reg;
        side11_next.err        = (den_reg == 31'sd0);
        side11_next.neg        = num_reg[63] ^ den_reg[30];
    end

    bsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (v_reg[11]),
        .num_in   (nmag_reg),
        .den_in   (dmag_reg),
        .side_in  (side11_reg),
        .vld_out  (dq_vld),
        .quot_out (dq_quot),
        .side_out (dq_side)
    );

    // Stage 12: signed quotient
    always_comb
    begin
        q12_next = dq_side.neg ? (64'd0 - dq_quot) : dq_quot;
    end

    // Stage 13: p9 and p8 products
    logic signed [50:0] qs13;
    logic signed [66:0] t9_prod;
    logic signed [47:0] ph8_prod;
    always_comb
    begin
        qs13     = $signed(q12_reg[63:13]);
        t9_prod  = p9 * qs13;
        t9_next  = t9_prod[63:0];
        a13_next = {{13{q12_reg[63]}}, q12_reg[63:13]};
        pl8_next = $signed({1'b0, q12_reg[31:0]}) * p8;
        ph8_prod = $signed(q12_reg[63:32]) * p8;
        ph8_next = ph8_prod[31:0];
    end

    // Stage 14: 64-bit wrapped square as partial products
    logic [63:0] lh_full, hl_full;
    always_comb
    begin
        ll_next = t9_reg[31:0] * a13_reg[31:0];
        lh_full = t9_reg[31:0] * a13_reg[63:32];
        hl_full = t9_reg[63:32] * a13_reg[31:0];
        lh_next = lh_full[31:0];
        hl_next = hl_full[31:0];
        b8_next = {{15{pl8_reg[48]}}, pl8_reg} + {ph8_reg, 32'b0};
    end

    // Stage 15: combine partials and scale
    logic [63:0] mq;
    logic [31:0] mid;
    always_comb
    begin
        mid     = lh_reg + hl_reg;
        mq      = ll_reg + {mid, 32'b0};
        c_next  = {{25{mq[63]}}, mq[63:25]};
        bb_next = {{19{b8_reg[63]}}, b8_reg[63:19]};
    end

    // Stage 16: correction sum
    always_comb
    begin
        s_next = q15_reg + c_reg + bb_reg;
    end

    // Output stage: offset, clamp, error override
    logic [63:0] pf;
    always_comb
    begin
        pf = {{8{s_reg[63]}}, s_reg[63:8]} + {{44{p7[15]}}, p7, 4'b0};
        result_next.temperature_centi = tc16_reg;
        result_next.div_error         = er16_reg;
        priority if (er16_reg || pf[63])
            result_next.pressure_q24_8 = '0;
        else if (pf > {39'b0, PRES_MAX_Q8})
            result_next.pressure_q24_8 = PRES_MAX_Q8;
        else
            result_next.pressure_q24_8 = pf[24:0];
    end

    // ------------------------------------------------------------------
    // Valid bits, output register and skid register occupancy
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg            <= '0;
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v_reg[11:1]  <= {v_reg[10:1], sample_valid};
                v_reg[16:12] <= {v_reg[15:12], dq_vld};
            end
            priority if (skid_valid_reg)
            begin
                // skid word moves to the output once the held result is taken
                if (!result_stall)
                    skid_valid_reg <= 1'b0;
            end
            else if (out_free)
                result_valid_reg <= v_reg[16];
            else if (v_reg[16])
                skid_valid_reg <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            at1_reg    <= sample.adc_temp;
            ap1_reg    <= sample.adc_pres;
            m1_reg     <= m1_next;
            sq_reg     <= sq_next;
            ap2_reg    <= ap1_reg;
            ta_reg     <= ta_next;
            m2_reg     <= m2_next;
            ap3_reg    <= ap2_reg;
            tfine_reg  <= tfine_next;
            ap4_reg    <= ap3_reg;
            tc5_reg    <= tc_next;
            av_reg     <= av_next;
            ap5_reg    <= ap4_reg;
            aa_reg     <= aa_next;
            ap2p_reg   <= ap2p_next;
            ap5p_reg   <= ap5p_next;
            tc6_reg    <= tc5_reg;
            ap6_reg    <= ap5_reg;
            b6_reg     <= b6_next;
            a3_reg     <= a3_next;
            ap2p7_reg  <= ap2p_reg;
            ap5p7_reg  <= ap5p_reg;
            tc7_reg    <= tc6_reg;
            ap7_reg    <= ap6_reg;
            b_reg      <= b_next;
            x_reg      <= x_next;
            tc8_reg    <= tc7_reg;
            ap8_reg    <= ap7_reg;
            pl_reg     <= pl_next;
            ph_reg     <= ph_next;
            n0_reg     <= n0_next;
            tc9_reg    <= tc8_reg;
            den_reg    <= den_next;
            num_reg    <= num_next;
            tc10_reg   <= tc9_reg;
            nmag_reg   <= nmag_next;
            dmag_reg   <= dmag_next;
            side11_reg <= side11_next;
            q12_reg    <= q12_next;
            tc12_reg   <= dq_side.temp_centi;
            er12_reg   <= dq_side.err;
            t9_reg     <= t9_next;
            a13_reg    <= a13_next;
            pl8_reg    <= pl8_next;
            ph8_reg    <= ph8_next;
            q13_reg    <= q12_reg;
            tc13_reg   <= tc12_reg;
            er13_reg   <= er12_reg;
            ll_reg     <= ll_next;
            lh_reg     <= lh_next;
            hl_reg     <= hl_next;
            b8_reg     <= b8_next;
            q14_reg    <= q13_reg;
            tc14_reg   <= tc13_reg;
            er14_reg   <= er13_reg;
            c_reg      <= c_next;
            bb_reg     <= bb_next;
            q15_reg    <= q14_reg;
            tc15_reg   <= tc14_reg;
            er15_reg   <= er14_reg;
            s_reg      <= s_next;
            tc16_reg   <= tc15_reg;
            er16_reg   <= er15_reg;
        end
    end

    // Output and skid words
    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (!result_stall)
                result_reg <= skid_reg;
        end
        else if (out_free)
            result_reg <= result_next;
        else
            skid_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // a zero divisor always gives zero pressure
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.div_error |-> result.pressure_q24_8 == 25'd0)
        else $error("div_error with nonzero pressure");

    // temperature stays inside its clamp range
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.temperature_centi >= TEMP_MIN_CENTI)
                      && (result.temperature_centi <= TEMP_MAX_CENTI))
        else $error("temperature out of range");

    // pressure stays inside its clamp range
    a_pres_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.pressure_q24_8 <= PRES_MAX_Q8)
        else $error("pressure out of range");

    // input is held back only while a result is pending
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid)
        else $error("input stalled without a pending result");

    // a stalled result stays valid and unchanged while it waits
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("waiting result changed");
`endif

endmodule
